// File: rtl/event_trace_ring_with_dump_top_assert.svh
// ----------------------------------------------------------------------------
// event trace ring assertion macros
// shared property shapes for the trace ring checks
// ----------------------------------------------------------------------------
`ifndef EVENT_TRACE_RING_WITH_DUMP_TOP_ASSERT_SVH
`define EVENT_TRACE_RING_WITH_DUMP_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define ETRD_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etrd same-cycle check failed");

// next-cycle implication, clocked on clk, off during rst
`define ETRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etrd next-cycle check failed");

`endif

// File: rtl/etrd_pkg.sv
// ----------------------------------------------------------------------------
// etrd_pkg
// types, codes and the character conversion of the event trace ring
// ----------------------------------------------------------------------------
package etrd_pkg;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] machine_state;
    logic [7:0] event_code;
  } in_word_t;

  typedef struct packed {
    logic [7:0] state_char;
    logic [7:0] event_char;
    logic       last;
  } out_word_t;

  // command handed from front to back
  typedef struct packed {
    logic       report;
    logic [7:0] machine_state;
    logic [7:0] event_code;
  } cmd_t;

  // back status seen by the top level
  typedef struct packed {
    logic dumping;
    logic rd_valid;
  } back_stat_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DUMP = 1'b1
  } back_state_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  localparam logic [7:0] SUPPRESS_RESET = 8'h03;
  localparam logic [7:0] CHAR_STAR      = 8'h2A;
  localparam logic [7:0] DIGIT_MAX      = 8'd9;
  localparam logic [7:0] DIGIT_OFS      = 8'h30;
  localparam logic [7:0] ALPHA_OFS      = 8'h37;

  // signed view: negative bytes count as digits
  function automatic logic [7:0] to_char(input logic [7:0] b);
    logic is_digit;
    is_digit = (b <= DIGIT_MAX) || b[7];
    return is_digit ? (b + DIGIT_OFS) : (b + ALPHA_OFS);
  endfunction

endpackage

// File: rtl/etrd_front.sv
// ----------------------------------------------------------------------------
// etrd_front
// accepts words, applies repeat suppression, holds the config register
// ----------------------------------------------------------------------------
module etrd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  etrd_pkg::in_word_t in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output etrd_pkg::cmd_t    q_cmd
);
  import etrd_pkg::*;

  logic [7:0] previous_event;
  logic [7:0] suppress_code;
  logic       accept;
  logic       is_record;
  logic       suppressed;

  assign cfg_ready  = 1'b1;
  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign is_record  = (in_data.op == OP_RECORD);
  assign suppressed = is_record && (in_data.event_code == suppress_code)
                      && (previous_event == suppress_code);
  assign q_push     = accept && !suppressed;

  always_comb begin
    q_cmd.report        = (in_data.op == OP_REPORT);
    q_cmd.machine_state = in_data.machine_state;
    q_cmd.event_code    = in_data.event_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_event <= 8'd0;
      suppress_code  <= SUPPRESS_RESET;
    end else begin
      if (accept && is_record) begin
        previous_event <= in_data.event_code;
      end
      if (cfg_valid && cfg_ready) begin
        suppress_code <= cfg_data;
      end
    end
  end

endmodule

// File: rtl/etrd_queue.sv
// ----------------------------------------------------------------------------
// etrd_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module etrd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  etrd_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           valid,
  input  logic           pop,
  output etrd_pkg::cmd_t pop_cmd
);
  import etrd_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/etrd_back.sv
// ----------------------------------------------------------------------------
// etrd_back
// ring memory, record writes and the dump sequencer with output register
// ----------------------------------------------------------------------------
module etrd_back #(
  parameter int unsigned PAIR_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  etrd_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output etrd_pkg::out_word_t out_data,
  output etrd_pkg::back_stat_t stat
);
  import etrd_pkg::*;

  localparam int unsigned SLOT_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PAIR_SLOTS - 1);

  logic [15:0]       mem [PAIR_SLOTS];
  back_state_t       state;
  back_state_t       state_next;
  logic [SLOT_W-1:0] write_slot;
  logic              has_wrapped;
  logic [SLOT_W-1:0] k;
  logic [SLOT_W-1:0] rd_addr;
  logic [15:0]       ram_q;
  logic              rd_valid;
  logic              rd_filled;
  logic              rd_last;
  logic              issue;
  logic              out_load;
  logic              is_last_issue;

  assign out_load      = rd_valid && (!out_valid || out_ready);
  assign is_last_issue = (k == LAST_SLOT);
  assign stat.dumping  = (state == BK_DUMP);
  assign stat.rd_valid = rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    issue      = 1'b0;
    case (state)
      BK_IDLE: begin
        q_pop = q_valid;
        if (q_valid && q_cmd.report) begin
          state_next = BK_DUMP;
        end
      end
      BK_DUMP: begin
        issue = !rd_valid || out_load;
        if (issue && is_last_issue) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // record writes
  always_ff @(posedge clk) begin
    if (q_pop && !q_cmd.report) begin
      mem[write_slot] <= {q_cmd.machine_state, q_cmd.event_code};
    end
  end

  // dump read port, registered
  always_ff @(posedge clk) begin
    if (issue) begin
      ram_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      has_wrapped <= 1'b0;
      k           <= '0;
      rd_addr     <= '0;
      rd_valid    <= 1'b0;
      rd_filled   <= 1'b0;
      rd_last     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop && !q_cmd.report) begin
        if (write_slot == LAST_SLOT) begin
          write_slot  <= '0;
          has_wrapped <= 1'b1;
        end else begin
          write_slot <= write_slot + 1'b1;
        end
      end
      if (q_pop && q_cmd.report) begin
        k       <= '0;
        rd_addr <= has_wrapped ? write_slot : '0;
      end
      if (issue) begin
        rd_filled <= has_wrapped || (k < write_slot);
        rd_last   <= is_last_issue;
        k         <= k + 1'b1;
        rd_addr   <= (rd_addr == LAST_SLOT) ? '0 : rd_addr + 1'b1;
        rd_valid  <= 1'b1;
      end else if (out_load) begin
        rd_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.state_char <= rd_filled ? to_char(ram_q[15:8]) : CHAR_STAR;
      out_data.event_char <= rd_filled ? to_char(ram_q[7:0]) : CHAR_STAR;
      out_data.last       <= rd_last;
    end
  end

endmodule

// File: rtl/event_trace_ring_with_dump_top.sv
// ----------------------------------------------------------------------------
// event_trace_ring_with_dump_top
// event trace ring with full dump in printable characters
// ----------------------------------------------------------------------------
// usage: in_valid/in_ready carry one word {op, machine_state, event_code}.
// a record word (op 0) stores the pair into the ring unless both it and the
// previous event equal suppress_code; it produces no output word. a report
// word (op 1) drains PAIR_SLOTS output words on out_valid/out_ready, oldest
// pair first, empty slots as '*','*', last set on the final word.
// cfg_valid/cfg_ready write suppress_code; cfg_ready is always high, write
// it only while the block is idle.
// throughput: one record word per cycle, buffered by the 4-entry command queue
// until it is full; a report occupies the back end for PAIR_SLOTS ring reads,
// one per cycle from the single memory read port while the output is not stalled.
// each dump word passes the ring read register and then the output register.
// reset: ring empty, not wrapped, previous event 0, suppress_code 3.
// a stalled receiver holds the output word; the dump pauses, the queue fills
// and in_ready drops once it is full.
// ----------------------------------------------------------------------------
module event_trace_ring_with_dump_top #(
  parameter int unsigned PAIR_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  etrd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output etrd_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import etrd_pkg::*;

  `include "event_trace_ring_with_dump_top_assert.svh"

  // front to queue
  logic       q_push;
  cmd_t       q_push_cmd;
  logic       q_full;
  // queue to back
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_pop_cmd;
  back_stat_t b_stat;

  // front: handshake, suppression and config register
  etrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd)
  );

  // decouples record intake from a long dump
  etrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd)
  );

  // back: ring memory, write pointer, wrap flag and dump sequencer
  etrd_back #(
    .PAIR_SLOTS (PAIR_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (b_stat)
  );

  // the front never pushes into a full queue
  `ETRD_ASSERT_IMPLY(a_no_overflow, q_push, !q_full)
  // a report taken from the queue starts the dump next cycle
  `ETRD_ASSERT_NEXT(a_report_starts, q_pop && q_pop_cmd.report, b_stat.dumping)
  // after a non-final word another word is still on its way
  `ETRD_ASSERT_NEXT(a_word_follows, out_valid && out_ready && !out_data.last,
                    out_valid || b_stat.rd_valid || b_stat.dumping)

endmodule

// File: test/trace_dump_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace dump checker
// follows every accepted word of the trace ring, keeps its own copy of the
// ring and predicts each dump word, then compares the words that come out
// ----------------------------------------------------------------------------
module trace_dump_checker #(
  parameter int unsigned PAIR_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  etrd_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  etrd_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  output int                  mismatches,
  output int                  words_owed
);
  import etrd_pkg::*;

  logic [7:0]  ring_state [PAIR_SLOTS];
  logic [7:0]  ring_event [PAIR_SLOTS];
  int unsigned next_slot;
  logic        wrapped;
  logic [7:0]  last_event;
  logic [7:0]  quiet_code;
  out_word_t   dump_owed_q[$];

  initial begin
    mismatches = 0;
    words_owed = 0;
  end

  // signed view of the byte: negative values take the digit offset
  function automatic logic [7:0] printable(input logic [7:0] b);
    if ($signed(b) <= $signed(DIGIT_MAX)) begin
      return b + DIGIT_OFS;
    end
    return b + ALPHA_OFS;
  endfunction

  task automatic take_word(input in_word_t w);
    out_word_t   o;
    int unsigned slot;
    if (w.op == OP_RECORD) begin
      if (!(w.event_code == quiet_code && last_event == quiet_code)) begin
        ring_state[next_slot] = w.machine_state;
        ring_event[next_slot] = w.event_code;
        if (next_slot == PAIR_SLOTS - 1) begin
          next_slot = 0;
          wrapped   = 1'b1;
        end else begin
          next_slot++;
        end
      end
      last_event = w.event_code;
    end else begin
      // oldest first; before the first wrap the tail is empty slots
      for (int k = 0; k < PAIR_SLOTS; k++) begin
        slot = wrapped ? (next_slot + k) % PAIR_SLOTS : k;
        if (wrapped || k < next_slot) begin
          o.state_char = printable(ring_state[slot]);
          o.event_char = printable(ring_event[slot]);
        end else begin
          o.state_char = CHAR_STAR;
          o.event_char = CHAR_STAR;
        end
        o.last = (k == PAIR_SLOTS - 1);
        dump_owed_q.push_back(o);
      end
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      next_slot  = 0;
      wrapped    = 1'b0;
      last_event = 8'h00;
      quiet_code = SUPPRESS_RESET;
      dump_owed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (dump_owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected dump word %h/%h last %b", $realtime,
                     out_data.state_char, out_data.event_char, out_data.last);
          end
        end else begin
          want = dump_owed_q.pop_front();
          if (out_data.state_char !== want.state_char ||
              out_data.event_char !== want.event_char ||
              out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: dump word expected %h/%h last %b, got %h/%h last %b",
                       $realtime, want.state_char, want.event_char, want.last,
                       out_data.state_char, out_data.event_char, out_data.last);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        quiet_code = cfg_data;
      end
      if (in_valid && in_ready) begin
        take_word(in_data);
      end
    end
    words_owed = dump_owed_q.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event trace ring testbench
// drives record and report words with bursty pacing and a stalling receiver,
// switches the suppress code between phases, and leaves all checking of the
// dump words to the checker beside the block
// ----------------------------------------------------------------------------
module testbench;
  import etrd_pkg::*;

  localparam int unsigned PAIR_SLOTS    = 64;
  localparam int          CYCLE_LIMIT   = 1000000;
  // records have no result, so after the last dump word the command queue
  // may still hold records; give it this long before touching the register
  localparam int          SETTLE_CYCLES = 16;
  localparam int          PHASES        = 5;
  localparam int          PHASE_WORDS   = 30;

  // receiver behavior: always ready, coin flip, or long chokes
  typedef enum int {
    RX_OPEN  = 0,
    RX_COIN  = 1,
    RX_CHOKE = 2
  } rx_mode_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_word_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = 8'h00;

  int mismatches;
  int words_owed;

  int       burst_left = 0;
  int       cycles     = 0;
  rx_mode_t rx_mode    = RX_OPEN;
  int       mode_left  = 0;
  int       choke_left = 0;

  event_trace_ring_with_dump_top #(
    .PAIR_SLOTS(PAIR_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  trace_dump_checker #(
    .PAIR_SLOTS(PAIR_SLOTS)
  ) dump_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .words_owed(words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: the stall pattern is redrawn whenever its mode count runs out so that
  // stalls land on every word of a dump, with open stretches in between
  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(40, 200);
      rx_mode   = rx_mode_t'($urandom_range(0, 2));
    end else begin
      mode_left--;
    end
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_COIN: begin
        out_ready <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        if (choke_left > 0) begin
          choke_left--;
          out_ready <= 1'b0;
        end else begin
          choke_left = $urandom_range(1, 8);
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // present one word and hold it until taken; afterwards either go idle for
  // a gap or return at once so the next word can follow back to back
  // (in_valid is never lowered and raised in the same step)
  task automatic send_word(input in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // mostly short bursts, now and then a long run with no idling
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic record_pair(input logic [7:0] st, input logic [7:0] ev);
    in_word_t w;
    w.op            = OP_RECORD;
    w.machine_state = st;
    w.event_code    = ev;
    send_word(w);
  endtask

  // operands of a report are don't-care, so they get random bytes
  task automatic report_dump();
    in_word_t w;
    w.op            = OP_REPORT;
    w.machine_state = 8'($urandom_range(0, 255));
    w.event_code    = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  // stop sending until every owed dump word has come out, then let the
  // command queue empty itself
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_owed != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // the suppress code only changes while the block is idle
  task automatic drain_then_write(input logic [7:0] code);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] code;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    report_dump();                // fresh ring: every slot reads as stars
    record_pair(8'h00, 8'h00);
    record_pair(8'hFF, 8'hFF);    // negative byte, digit offset
    record_pair(8'h09, 8'h0A);    // last digit and first letter
    record_pair(8'h80, 8'h7F);    // most negative and most positive
    record_pair(8'h81, 8'h03);    // suppress code after another event, kept
    record_pair(8'h12, 8'h03);    // back-to-back suppress code, dropped
    record_pair(8'h13, 8'h03);    // dropped again
    record_pair(8'h14, 8'h04);
    record_pair(8'h15, 8'h03);    // kept, previous event differs
    report_dump();                // partial ring
    drain_then_write(8'h00);
    record_pair(8'h5A, 8'h00);    // previous event was 3, kept
    record_pair(8'hA5, 8'h00);    // repeat of new code, dropped
    record_pair(8'h3C, 8'h01);
    report_dump();
    drain_then_write(8'hFF);
    record_pair(8'hC3, 8'hFF);
    record_pair(8'h7E, 8'hFF);    // dropped
    record_pair(8'h0F, 8'hFE);
    report_dump();

    // ---- random part: one phase per suppress code ----
    // records dominate so the ring wraps; the event byte is
    // often the suppress code to hit the repeat filter
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       code = SUPPRESS_RESET;
        1:       code = 8'h00;
        2:       code = 8'hFF;
        default: code = 8'($urandom_range(0, 255));
      endcase
      drain_then_write(code);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          report_dump();
        end else if ($urandom_range(0, 4) < 2) begin
          record_pair(8'($urandom_range(0, 255)), code);
        end else begin
          record_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        // hold the sender mid-phase until the dump pipeline is empty
        if (p == 1 && n == PHASE_WORDS / 2) begin
          wait_drained();
        end
      end
    end

    // ---- wind down and verdict ----
    wait_drained();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
